### rtl/kr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kr_pkg;

    // One stored record: key, packed name characters, marks in hundredths.
    typedef struct packed {
        logic signed [31:0] key;
        logic        [63:0] name;
        logic        [15:0] marks;
    } t_rec;

    // Per-cell control broadcast from the sequencer.
    typedef struct packed {
        logic shift;    // every cell takes its neighbor's record (ring rotation)
        logic compact;  // cells at or above the delete position take their neighbor
    } t_cell_ctl;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_SEARCH = 2'd1,
        CMD_UPDATE = 2'd2,
        CMD_DELETE = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_DUPLICATE = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

endpackage

`default_nettype wire

### rtl/kr_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module kr_cell #(
    parameter int IDX_W = 6,
    parameter int IDX   = 0
) (
    input  wire                    i_clk,
    input  wire kr_pkg::t_cell_ctl i_ctl,
    input  wire [IDX_W-1:0]        i_del_pos,
    input  wire kr_pkg::t_rec      i_next,
    output kr_pkg::t_rec           o_rec
);

    kr_pkg::t_rec r_rec;
    logic         w_take;

    // Take the neighbor's record on rotation, or on compaction at or above the hole.
    assign w_take = i_ctl.shift || (i_ctl.compact && (IDX_W'(IDX) >= i_del_pos));

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_rec <= i_next;
        end
    end

    assign o_rec = r_rec;

endmodule

`default_nettype wire

### rtl/keyed_record_table.sv
// Flow: each accepted item runs through S_SCAN (and S_COMPACT for a delete that hits) and S_OUT.
// A new item is taken only in S_IDLE, after the last result is loaded; the ring
//   of DEPTH record cells rotates once through the head compare per item.
// Reset: synchronous, active low; clears the record count, sequencer and output valid.
//   Record cells are not cleared; only positions below the count are ever read.
`timescale 1ns / 1ps
`default_nettype none

module keyed_record_table #(
    parameter int DEPTH = 64
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    // Command side
    input  wire          i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  wire [143:0]  i_s_axis_tdata,   // lookup_key[31:0], new_key[63:32],
                                           // name_payload[127:64], marks_value[143:128]
    input  wire [1:0]    i_s_axis_tuser,   // command[1:0]
    // Result side
    output logic         o_m_axis_tvalid,
    input  wire          i_m_axis_tready,
    output logic [95:0]  o_m_axis_tdata,   // hit_index[5:0], name_out[69:6],
                                           // marks_out[85:70], record_count[92:86], zero pad
    output logic [1:0]   o_m_axis_tuser    // status[1:0]
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    // One-hot sequencer states
    typedef enum logic [3:0] {
        S_IDLE    = 4'b0001,
        S_SCAN    = 4'b0010,
        S_COMPACT = 4'b0100,
        S_OUT     = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // Latched command
    kr_pkg::t_cmd       r_cmd,     n_cmd;
    logic signed [31:0] r_lookup,  n_lookup;
    logic signed [31:0] r_new_key, n_new_key;
    logic        [63:0] r_name,    n_name;
    logic        [15:0] r_marks,   n_marks;

    // Scan progress
    logic [CNT_W-1:0]   r_step,  n_step;
    logic               r_hit,   n_hit;
    logic [IDX_W-1:0]   r_pos,   n_pos;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [63:0]        r_name_o,  n_name_o;
    logic [15:0]        r_marks_o, n_marks_o;

    // Output register
    logic               r_m_valid, n_m_valid;
    logic [95:0]        r_m_tdata, n_m_tdata;
    logic [1:0]         r_m_tuser, n_m_tuser;

    // Cell ring
    kr_pkg::t_rec       w_rec [DEPTH];
    kr_pkg::t_rec       w_feed;
    kr_pkg::t_rec       w_head;
    kr_pkg::t_cell_ctl  w_ctl;

    logic               w_hit_now;
    logic               w_ins_now;
    logic               w_full;
    logic               w_last_step;
    logic               w_out_free;

    // Result assembly
    kr_pkg::t_status    w_status;
    logic [IDX_W-1:0]   w_idx;
    logic [CNT_W-1:0]   w_cnt_after;
    logic [IDX_W+5:0]   w_idx_ext;
    logic [CNT_W+6:0]   w_cnt_ext;
    logic [63:0]        w_name_res;
    logic [15:0]        w_marks_res;

    // ------------------------------------------------------------------
    // Record ring: cell 0 is the head, the tail takes the feed record.
    // ------------------------------------------------------------------
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            if (gi == DEPTH - 1) begin : g_tail
                kr_cell #(
                    .IDX_W (IDX_W),
                    .IDX   (gi)
                ) u_cell (
                    .i_clk     (i_clk),
                    .i_ctl     (w_ctl),
                    .i_del_pos (r_pos),
                    .i_next    (w_feed),
                    .o_rec     (w_rec[gi])
                );
            end else begin : g_body
                kr_cell #(
                    .IDX_W (IDX_W),
                    .IDX   (gi)
                ) u_cell (
                    .i_clk     (i_clk),
                    .i_ctl     (w_ctl),
                    .i_del_pos (r_pos),
                    .i_next    (w_rec[gi+1]),
                    .o_rec     (w_rec[gi])
                );
            end
        end
    endgenerate

    assign w_head = w_rec[0];

    // During a scan step the head holds the record at position r_step.
    assign w_full      = (r_count == CNT_W'(DEPTH));
    assign w_last_step = (r_step == CNT_W'(DEPTH - 1));
    assign w_hit_now   = (w_head.key == r_lookup) && (r_step < r_count) && !r_hit;
    assign w_ins_now   = (r_cmd == kr_pkg::CMD_INSERT) && (r_step == r_count) && !r_hit;

    assign w_ctl.shift   = (r_state == S_SCAN);
    assign w_ctl.compact = (r_state == S_COMPACT);

    // Feed the head back to the tail; replace it where the command writes.
    always_comb begin
        w_feed = w_head;
        if (w_ins_now) begin
            w_feed.key = r_lookup;
            w_feed.name = r_name;
            w_feed.marks = r_marks;
        end else if (w_hit_now && (r_cmd == kr_pkg::CMD_UPDATE)) begin
            w_feed.key = r_new_key;
            w_feed.name = r_name;
            w_feed.marks = r_marks;
        end
    end

    // ------------------------------------------------------------------
    // Result of the finished command
    // ------------------------------------------------------------------
    always_comb begin
        w_status    = kr_pkg::ST_OK;
        w_idx       = '0;
        w_cnt_after = r_count;
        w_name_res  = '0;
        w_marks_res = '0;
        case (r_cmd)
            kr_pkg::CMD_INSERT: begin
                if (r_hit) begin
                    w_status = kr_pkg::ST_DUPLICATE;
                    w_idx    = r_pos;
                end else if (w_full) begin
                    w_status = kr_pkg::ST_FULL;
                end else begin
                    w_idx       = r_count[IDX_W-1:0];
                    w_cnt_after = r_count + CNT_W'(1);
                end
            end
            kr_pkg::CMD_SEARCH: begin
                if (r_hit) begin
                    w_idx       = r_pos;
                    w_name_res  = r_name_o;
                    w_marks_res = r_marks_o;
                end else begin
                    w_status = kr_pkg::ST_NOT_FOUND;
                end
            end
            kr_pkg::CMD_UPDATE: begin
                if (r_hit) begin
                    w_idx = r_pos;
                end else begin
                    w_status = kr_pkg::ST_NOT_FOUND;
                end
            end
            kr_pkg::CMD_DELETE: begin
                if (r_hit) begin
                    w_idx       = r_pos;
                    w_cnt_after = r_count - CNT_W'(1);
                end else begin
                    w_status = kr_pkg::ST_NOT_FOUND;
                end
            end
            default: begin
                w_status = kr_pkg::ST_OK;
            end
        endcase
    end

    // Reduce index and count to the port widths (modulo 64 and 128).
    assign w_idx_ext = {6'b0, w_idx};
    assign w_cnt_ext = {7'b0, w_cnt_after};

    assign w_out_free = !r_m_valid || i_m_axis_tready;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_lookup  = r_lookup;
        n_new_key = r_new_key;
        n_name    = r_name;
        n_marks   = r_marks;
        n_step    = r_step;
        n_hit     = r_hit;
        n_pos     = r_pos;
        n_count   = r_count;
        n_name_o  = r_name_o;
        n_marks_o = r_marks_o;
        n_m_valid = r_m_valid;
        n_m_tdata = r_m_tdata;
        n_m_tuser = r_m_tuser;

        // Drop the result once the sink takes it.
        if (r_m_valid && i_m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_cmd     = kr_pkg::t_cmd'(i_s_axis_tuser);
                    n_lookup  = i_s_axis_tdata[31:0];
                    n_new_key = i_s_axis_tdata[63:32];
                    n_name    = i_s_axis_tdata[127:64];
                    n_marks   = i_s_axis_tdata[143:128];
                    n_step    = '0;
                    n_hit     = 1'b0;
                    n_state   = S_SCAN;
                end
            end
            S_SCAN: begin
                // Advance the ring by one; compare the record passing the head.
                if (w_hit_now) begin
                    n_hit     = 1'b1;
                    n_pos     = r_step[IDX_W-1:0];
                    n_name_o  = w_head.name;
                    n_marks_o = w_head.marks;
                end
                n_step = r_step + CNT_W'(1);
                if (w_last_step) begin
                    if ((r_cmd == kr_pkg::CMD_DELETE) && (r_hit || w_hit_now)) begin
                        n_state = S_COMPACT;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_COMPACT: begin
                // Close the hole left by the deleted record: cells at or above it take their neighbor.
                n_state = S_OUT;
            end
            S_OUT: begin
                // Hold until the output register is free, then load the result.
                if (w_out_free) begin
                    n_m_valid = 1'b1;
                    n_m_tuser = w_status;
                    n_m_tdata = {3'b0, w_cnt_ext[6:0], w_marks_res, w_name_res,
                                 w_idx_ext[5:0]};
                    n_count   = w_cnt_after;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_lookup  <= n_lookup;
        r_new_key <= n_new_key;
        r_name    <= n_name;
        r_marks   <= n_marks;
        r_step    <= n_step;
        r_hit     <= n_hit;
        r_pos     <= n_pos;
        r_name_o  <= n_name_o;
        r_marks_o <= n_marks_o;
        r_m_tdata <= n_m_tdata;
        r_m_tuser <= n_m_tuser;
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_tdata;
    assign o_m_axis_tuser  = r_m_tuser;

endmodule

`default_nettype wire
